/* rtl/core/periodic_pulse_waveform_generator_core_assert.svh */
// Assertion macros shared by the pulse generator RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef PERIODIC_PULSE_WAVEFORM_GENERATOR_CORE_ASSERT_SVH
`define PERIODIC_PULSE_WAVEFORM_GENERATOR_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PPWG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PPWG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ppwg_pkg.sv */
// Shared types and register codes for the pulse waveform generator.
// No dependencies.
`default_nettype none
package ppwg_pkg;

	localparam int unsigned REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_LOW_LEVEL    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_LEVEL   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_TICKS  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RISE_TICKS   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FALL_TICKS   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH_TICKS  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD_TICKS = 3'd6;

	// Ramp control carried alongside the scaled quotient.
	typedef struct packed {
		logic ramp; // item lies on a rising or falling edge
		logic neg;  // subtract the quotient from the start level
	} ramp_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/ppwg_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; used for the period reduction and the ramp scaling.
`default_nettype none
module ppwg_div #(
	parameter int unsigned DW = 32,
	parameter int unsigned QW = 32,
	parameter int unsigned SW = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [DW+QW-1:0] num,
	input  wire logic [DW-1:0]    den,
	input  wire logic [SW-1:0]    side_in,
	output logic                  out_valid,
	output logic [QW-1:0]         quot,
	output logic [DW-1:0]         rem,
	output logic [SW-1:0]         side_out
);

	logic          v_s    [QW];
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] lo_s   [QW];
	logic [QW-1:0] quot_s [QW];
	logic [DW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic          v_prev;
		logic [DW-1:0] rem_prev;
		logic [QW-1:0] lo_prev;
		logic [QW-1:0] quot_prev;
		logic [DW-1:0] den_prev;
		logic [SW-1:0] side_prev;
		logic [DW:0]   cand;
		logic          ge;

		if (g == 0) begin : g_first
			assign v_prev    = in_valid;
			assign rem_prev  = num[DW+QW-1:QW];
			assign lo_prev   = num[QW-1:0];
			assign quot_prev = '0;
			assign den_prev  = den;
			assign side_prev = side_in;
		end else begin : g_next
			assign v_prev    = v_s[g-1];
			assign rem_prev  = rem_s[g-1];
			assign lo_prev   = lo_s[g-1];
			assign quot_prev = quot_s[g-1];
			assign den_prev  = den_s[g-1];
			assign side_prev = side_s[g-1];
		end

		assign cand = {rem_prev, lo_prev[QW-1]};
		assign ge   = cand >= {1'b0, den_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? DW'(cand - {1'b0, den_prev}) : cand[DW-1:0];
				lo_s[g]   <= {lo_prev[QW-2:0], 1'b0};
				quot_s[g] <= {quot_prev[QW-2:0], ge};
				den_s[g]  <= den_prev;
				side_s[g] <= side_prev;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quot      = quot_s[QW-1];
	assign rem       = rem_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule
`default_nettype wire

/* rtl/core/ppwg_seg.sv */
// Segment classification and ramp product, two pipeline stages.
// Depends on ppwg_pkg.
`default_nettype none
module ppwg_seg
	import ppwg_pkg::*;
#(
	parameter int unsigned TW = 32,
	parameter int unsigned LW = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [TW-1:0]        tm,
	input  wire logic                 zero_period,
	input  wire logic signed [LW-1:0] low_level,
	input  wire logic signed [LW-1:0] high_level,
	input  wire logic [TW-1:0]        delay_ticks,
	input  wire logic [TW-1:0]        rise_ticks,
	input  wire logic [TW-1:0]        fall_ticks,
	input  wire logic [TW-1:0]        width_ticks,
	output logic                      out_valid,
	output logic [TW+LW:0]            prod,
	output logic [TW-1:0]             span,
	output logic [LW-1:0]             from,
	output ramp_ctl_t                 ctl
);

	localparam int unsigned EW = TW + 2;

	logic [EW-1:0]        e1, e2, e3, e4, tm_x;
	logic signed [LW:0]   diff;
	logic [LW:0]          mag;
	logic                 in_rise, in_high, in_fall;
	logic [TW-1:0]        elapsed_c, span_c;
	logic [LW-1:0]        from_c;
	logic [LW:0]          mag_c;
	ramp_ctl_t            ctl_c;

	logic                 v_s1, v_s2;
	logic [TW-1:0]        elapsed_s1, span_s1, span_s2;
	logic [LW-1:0]        from_s1, from_s2;
	logic [LW:0]          mag_s1;
	ramp_ctl_t            ctl_s1, ctl_s2;
	logic [TW+LW:0]       prod_s2;

	// Segment ends summed without wrap.
	assign e1   = EW'(delay_ticks);
	assign e2   = e1 + EW'(rise_ticks);
	assign e3   = e2 + EW'(width_ticks);
	assign e4   = e3 + EW'(fall_ticks);
	assign tm_x = EW'(tm);

	assign diff = (LW+1)'(high_level) - (LW+1)'(low_level);
	assign mag  = diff[LW] ? (LW+1)'(-diff) : diff;

	assign in_rise = !zero_period && tm_x >= e1 && tm_x < e2;
	assign in_high = !zero_period && tm_x >= e2 && tm_x < e3;
	assign in_fall = !zero_period && tm_x >= e3 && tm_x < e4;

	always_comb begin
		elapsed_c = '0;
		span_c    = TW'(1);
		mag_c     = '0;
		from_c    = low_level;
		ctl_c     = '{ramp: 1'b0, neg: 1'b0};
		if (in_rise) begin
			elapsed_c = TW'(tm_x - e1);
			span_c    = rise_ticks;
			mag_c     = mag;
			ctl_c     = '{ramp: 1'b1, neg: diff[LW]};
		end else if (in_high) begin
			from_c = high_level;
		end else if (in_fall) begin
			elapsed_c = TW'(tm_x - e3);
			span_c    = fall_ticks;
			mag_c     = mag;
			from_c    = high_level;
			ctl_c     = '{ramp: 1'b1, neg: !diff[LW] && (diff != '0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			elapsed_s1 <= elapsed_c;
			span_s1    <= span_c;
			from_s1    <= from_c;
			mag_s1     <= mag_c;
			ctl_s1     <= ctl_c;
			prod_s2    <= mag_s1 * (TW+LW+1)'(elapsed_s1);
			span_s2    <= span_s1;
			from_s2    <= from_s1;
			ctl_s2     <= ctl_s1;
		end
	end

	assign out_valid = v_s2;
	assign prod      = prod_s2;
	assign span      = span_s2;
	assign from      = from_s2;
	assign ctl       = ctl_s2;

endmodule
`default_nettype wire

/* rtl/core/periodic_pulse_waveform_generator_core.sv */
// Periodic trapezoid pulse generator: time stamp in, pulse level out.
// Depends on ppwg_pkg, ppwg_div, ppwg_seg and the assertion macro header.
//
// Each transaction on the s_ side carries a tick time stamp; the matching
// m_ transaction carries the waveform level at that time. The block takes one
// transaction per clock unless a stall on m_tready, which freezes the whole
// pipeline, holds it, and returns results in order: TIME_WIDTH divider stages
// reduce the time modulo the period, two stages classify the segment and
// form the ramp product, LEVEL_WIDTH + 1 divider stages scale it by the ramp
// length, and one stage adds the quotient to or subtracts it from the start
// level. The user must write registers through cfg_we/cfg_index/cfg_wdata
// only while no transaction is in flight; the block does not enforce this.
`default_nettype none
module periodic_pulse_waveform_generator_core
	import ppwg_pkg::*;
#(
	parameter int unsigned TIME_WIDTH  = 32,
	parameter int unsigned LEVEL_WIDTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [REG_IDX_W-1:0]              cfg_index,
	input  wire logic [((TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH)-1:0] cfg_wdata,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [((TIME_WIDTH+7)/8)*8-1:0]   s_tdata,  // time_ticks
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [((LEVEL_WIDTH+7)/8)*8-1:0]       m_tdata   // level
);

	localparam int unsigned TW  = TIME_WIDTH;
	localparam int unsigned LW  = LEVEL_WIDTH;
	localparam int unsigned QW  = LW + 1;
	localparam int unsigned ODW = ((LW + 7) / 8) * 8;
	localparam int unsigned SW  = LW + $bits(ramp_ctl_t);

	logic signed [LW-1:0] low_q, high_q;
	logic [TW-1:0]        delay_q, rise_q, fall_q, width_q, period_q;

	logic                 en;
	logic                 mdiv_valid;
	logic [TW-1:0]        mdiv_quot, mdiv_rem;
	logic                 mdiv_zero;

	logic                 seg_valid;
	logic [TW+LW:0]       seg_prod;
	logic [TW-1:0]        seg_span;
	logic [LW-1:0]        seg_from;
	ramp_ctl_t            seg_ctl;

	logic                 rdiv_valid;
	logic [QW-1:0]        rdiv_quot;
	logic [TW-1:0]        rdiv_rem;
	logic [SW-1:0]        rdiv_side;
	logic [LW-1:0]        rdiv_from;
	ramp_ctl_t            rdiv_ctl;

	logic                 out_v_q;
	logic [LW-1:0]        level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= '0;
			high_q   <= '0;
			delay_q  <= '0;
			rise_q   <= TW'(1);
			fall_q   <= TW'(1);
			width_q  <= '0;
			period_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_LEVEL:    low_q    <= cfg_wdata[LW-1:0];
				REG_HIGH_LEVEL:   high_q   <= cfg_wdata[LW-1:0];
				REG_DELAY_TICKS:  delay_q  <= cfg_wdata[TW-1:0];
				REG_RISE_TICKS:   rise_q   <= cfg_wdata[TW-1:0];
				REG_FALL_TICKS:   fall_q   <= cfg_wdata[TW-1:0];
				REG_WIDTH_TICKS:  width_q  <= cfg_wdata[TW-1:0];
				REG_PERIOD_TICKS: period_q <= cfg_wdata[TW-1:0];
				default: ;
			endcase
		end
	end

	// Advance the whole pipeline unless the output holds an untaken result.
	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	ppwg_div #(.DW(TW), .QW(TW), .SW(1)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.num       ({{TW{1'b0}}, s_tdata[TW-1:0]}),
		.den       (period_q),
		.side_in   (period_q == '0),
		.out_valid (mdiv_valid),
		.quot      (mdiv_quot),
		.rem       (mdiv_rem),
		.side_out  (mdiv_zero)
	);

	ppwg_seg #(.TW(TW), .LW(LW)) u_seg (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (mdiv_valid),
		.tm          (mdiv_rem),
		.zero_period (mdiv_zero),
		.low_level   (low_q),
		.high_level  (high_q),
		.delay_ticks (delay_q),
		.rise_ticks  (rise_q),
		.fall_ticks  (fall_q),
		.width_ticks (width_q),
		.out_valid   (seg_valid),
		.prod        (seg_prod),
		.span        (seg_span),
		.from        (seg_from),
		.ctl         (seg_ctl)
	);

	ppwg_div #(.DW(TW), .QW(QW), .SW(SW)) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (seg_valid),
		.num       (seg_prod),
		.den       (seg_span),
		.side_in   ({seg_from, seg_ctl}),
		.out_valid (rdiv_valid),
		.quot      (rdiv_quot),
		.rem       (rdiv_rem),
		.side_out  (rdiv_side)
	);

	assign rdiv_from = rdiv_side[SW-1:$bits(ramp_ctl_t)];
	assign rdiv_ctl  = rdiv_side[$bits(ramp_ctl_t)-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= rdiv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_q <= rdiv_ctl.neg ? rdiv_from - rdiv_quot[LW-1:0]
			                        : rdiv_from + rdiv_quot[LW-1:0];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = ODW'(level_q);

	`include "periodic_pulse_waveform_generator_core_assert.svh"

	// A flat segment divides zero by one.
	`PPWG_ASSERT_SAME(a_flat_no_quot, rdiv_valid && !rdiv_ctl.ramp, rdiv_quot == '0 && rdiv_rem == '0, "flat segment produced a nonzero ramp quotient")
	`PPWG_ASSERT_SAME(a_quot_range, rdiv_valid, !rdiv_quot[QW-1], "ramp quotient out of range")
	`PPWG_ASSERT_SAME(a_mod_range, mdiv_valid && !mdiv_zero, mdiv_rem < period_q, "reduced time not below the period")
	`PPWG_ASSERT_SAME(a_zero_quot, mdiv_valid && mdiv_zero, &mdiv_quot, "zero period did not saturate the quotient")
	`PPWG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for periodic_pulse_waveform_generator_core.
// Depends on ppwg_pkg and the core RTL; predicts each pulse level from shadow
// register copies and checks every m_ transaction in order.
module tb_top;
	import ppwg_pkg::*;

	localparam int unsigned TW = 32;
	localparam int unsigned LW = 16;
	localparam int unsigned DEPTH = TW + LW + 4;
	localparam int unsigned IDLE_LIMIT = 5000;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef struct {
		logic [31:0] lo, hi, dly, rise, fall, wid, per;
	} pulse_cfg_t;

	typedef struct {
		int          phase;
		logic [31:0] t;
		bit          known;
		shortint     lvl;
	} stim_row_t;

	typedef struct {
		bit      known;
		shortint lvl;
	} typed_t;

	typedef struct {
		typed_t  typed;
		shortint pred;
	} level_exp_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic [2:0]    cfg_index = '0;
	logic [31:0]   cfg_wdata = '0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [31:0]   s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b1;
	logic [15:0]   m_tdata;

	// shadow copies of the block's registers
	logic signed [15:0] sh_lo = 16'sd0, sh_hi = 16'sd0;
	logic [31:0]        sh_dly = 0, sh_rise = 1, sh_fall = 1, sh_wid = 0, sh_per = 0;

	typed_t     typed_q[$];
	level_exp_t level_q[$];
	int         errors = 0;
	int         idle_cycles = 0;
	bit         quiet = 0;
	bit         hold_req = 0;

	pulse_cfg_t cfg_set[4];
	stim_row_t  rows[$];

	periodic_pulse_waveform_generator_core #(.TIME_WIDTH(TW), .LEVEL_WIDTH(LW)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	function automatic longint ramp_level(longint from, longint to,
			longint unsigned el, longint unsigned span);
		longint          diff;
		longint unsigned mag;
		diff = to - from;
		if (diff >= 0) begin
			mag = (longint'(diff) * el) / span;
			return from + longint'(mag);
		end
		mag = (longint'(-diff) * el) / span;
		return from - longint'(mag);
	endfunction

	function automatic shortint pulse_level(logic [31:0] t);
		longint          lo, hi, res;
		longint unsigned tm, e1, e2, e3, e4;
		lo = sh_lo;
		hi = sh_hi;
		res = lo;
		if (sh_per != 0) begin
			tm = longint'(t) % longint'(sh_per);
			e1 = sh_dly;
			e2 = e1 + sh_rise;
			e3 = e2 + sh_wid;
			e4 = e3 + sh_fall;
			if (tm < e1) res = lo;
			else if (tm < e2) res = ramp_level(lo, hi, tm - e1, e2 - e1);
			else if (tm < e3) res = hi;
			else if (tm < e4) res = ramp_level(hi, lo, tm - e3, e4 - e3);
			else res = lo;
		end
		return shortint'(res);
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// transactions complete at the next rising edge; all signals are stable here
	always @(negedge clk) begin
		level_exp_t e;
		shortint    want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				e.typed = typed_q.pop_front();
				e.pred = pulse_level(s_tdata);
				level_q = {level_q, e};
			end
			if (m_tvalid && m_tready) begin
				if (level_q.size() == 0) begin
					report_mismatch($sformatf("unexpected level %0d", $signed(m_tdata)));
				end else begin
					e = level_q.pop_front();
					want = e.typed.known ? e.typed.lvl : e.pred;
					if ($signed(m_tdata) != want)
						report_mismatch($sformatf("level %0d, expected %0d",
							$signed(m_tdata), want));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[periodic_pulse_waveform_generator_core] ERROR");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	always begin
		@(posedge clk);
		if (hold_req) begin
			m_tready <= 1'b0;
			repeat (300) @(posedge clk);
			hold_req = 0;
			m_tready <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			m_tready <= 1'b1;
		end
	end

	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_LOW_LEVEL:    sh_lo = val[15:0];
			REG_HIGH_LEVEL:   sh_hi = val[15:0];
			REG_DELAY_TICKS:  sh_dly = val;
			REG_RISE_TICKS:   sh_rise = val;
			REG_FALL_TICKS:   sh_fall = val;
			REG_WIDTH_TICKS:  sh_wid = val;
			REG_PERIOD_TICKS: sh_per = val;
			default: ;
		endcase
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (level_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	task automatic load_cfg(pulse_cfg_t c);
		drain();
		write_reg(REG_LOW_LEVEL, c.lo);
		write_reg(REG_HIGH_LEVEL, c.hi);
		write_reg(REG_DELAY_TICKS, c.dly);
		write_reg(REG_RISE_TICKS, c.rise);
		write_reg(REG_FALL_TICKS, c.fall);
		write_reg(REG_WIDTH_TICKS, c.wid);
		write_reg(REG_PERIOD_TICKS, c.per);
		write_reg(REG_UNMAPPED, $urandom());
		cfg_we <= 1'b0;
	endtask

	task automatic put_time(logic [31:0] t, bit known, shortint lvl);
		typed_t ty;
		ty.known = known;
		ty.lvl = lvl;
		typed_q = {typed_q, ty};
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_span(bit short_per);
		if (short_per) return $urandom_range(0, 20);
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 100);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_level;
		case ($urandom_range(0, 5))
			0: return {16'($urandom_range(0, 65535)), 16'h7FFF};
			1: return {16'($urandom_range(0, 65535)), 16'h8000};
			default: return $urandom();
		endcase
	endfunction

	function automatic pulse_cfg_t rand_cfg;
		pulse_cfg_t c;
		bit         short_per;
		short_per = $urandom_range(0, 2) != 0;
		c.lo = rand_level();
		c.hi = rand_level();
		c.dly = rand_span(short_per);
		c.rise = rand_span(short_per);
		c.fall = rand_span(short_per);
		c.wid = rand_span(short_per);
		if (short_per) c.per = $urandom_range(1, 80);
		else case ($urandom_range(0, 3))
			0: c.per = 32'd0;
			1: c.per = 32'hFFFF_FFFF;
			default: c.per = $urandom();
		endcase
		return c;
	endfunction

	function automatic logic [31:0] rand_time;
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom();
			4: return sh_per + $urandom_range(0, 3) - 2;
			default: return $urandom_range(0, 300);
		endcase
	endfunction

	initial begin
		int phase;
		cfg_set[0] = '{lo: 0, hi: 0, dly: 0, rise: 1, fall: 1, wid: 0, per: 0};
		cfg_set[1] = '{lo: 32'hFFFF_FF9C, hi: 32'd100, dly: 10, rise: 4, fall: 0,
			wid: 5, per: 30};
		// extremes, with garbage in the unused level bits
		cfg_set[2] = '{lo: 32'h1234_7FFF, hi: 32'hABCD_8000, dly: 32'hFFFF_FFFF,
			rise: 32'hFFFF_FFFF, fall: 32'hFFFF_FFFF, wid: 32'hFFFF_FFFF,
			per: 32'hFFFF_FFFF};
		cfg_set[3] = '{lo: 32'h0000_8000, hi: 32'h0000_7FFF, dly: 0,
			rise: 32'hFFFF_FFFF, fall: 0, wid: 0, per: 32'hFFFF_FFFF};

		rows = '{
			'{0, 32'd0, 1, 0}, '{0, 32'hFFFF_FFFF, 1, 0},
			'{1, 32'd0, 1, -100}, '{1, 32'd9, 1, -100}, '{1, 32'd10, 1, -100},
			'{1, 32'd11, 0, 0}, '{1, 32'd12, 1, 0}, '{1, 32'd13, 0, 0},
			'{1, 32'd14, 1, 100}, '{1, 32'd18, 1, 100}, '{1, 32'd19, 1, -100},
			'{1, 32'd29, 1, -100}, '{1, 32'd40, 1, -100}, '{1, 32'hFFFF_FFFF, 1, 100},
			'{2, 32'd0, 1, 32767}, '{2, 32'hFFFF_FFFE, 1, 32767},
			'{2, 32'hFFFF_FFFF, 1, 32767},
			'{3, 32'd0, 1, -32768}, '{3, 32'd1, 0, 0}, '{3, 32'h8000_0000, 0, 0},
			'{3, 32'hFFFF_FFFE, 0, 0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; reset values hold for the first rows
		phase = 0;
		foreach (rows[i]) begin
			if (rows[i].phase != phase) begin
				phase = rows[i].phase;
				load_cfg(cfg_set[phase]);
			end
			put_time(rows[i].t, rows[i].known, rows[i].lvl);
		end

		for (int p = 0; p < 8; p++) begin
			load_cfg(rand_cfg());
			quiet = (p == 7);
			for (int n = 0; n < 85; n++) begin
				if (p == 0 && n == 5) hold_req = 1;
				if (p == 1 && n == 40) drain();
				put_time(rand_time(), 0, 0);
			end
		end

		drain();
		if (errors == 0)
			$display("[periodic_pulse_waveform_generator_core] OK");
		else
			$display("[periodic_pulse_waveform_generator_core] ERROR");
		$finish;
	end
endmodule

/* periodic_pulse_waveform_generator_core.f */
+incdir+rtl/core
rtl/core/ppwg_pkg.sv
rtl/core/ppwg_div.sv
rtl/core/ppwg_seg.sv
rtl/core/periodic_pulse_waveform_generator_core.sv
sim/tb_top.sv
